>>> rtl/snp_pkg.sv
// snp_pkg: widths, register indexes, reset values and shared types of the
// snowpack nutrient step unit; no dependencies, imported by every rtl module
package snp_pkg;

  // field widths
  localparam int WATER_W  = 22;   // snowpack and rain, Q.8 mm
  localparam int PREC_W   = 19;
  localparam int TEMP_W   = 16;
  localparam int THR_W    = 13;
  localparam int COEF_W   = 16;
  localparam int DEP_W    = 24;
  localparam int DEP_IN_W = 25;   // deposition plus fertilizer share
  localparam int POOL_W   = 32;
  localparam int NUM_POOLS = 3;
  localparam int POOL_IDX_W = 2;

  // shared multiplier operand widths
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 22;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // divider: 54-bit dividend, 22-bit divisor, 32-bit quotient
  localparam int DIV_D_W = 22;
  localparam int DIV_Q_W = 32;
  localparam int DIV_N_W = DIV_D_W + DIV_Q_W;
  localparam int DIV_CNT_W = $clog2(DIV_Q_W);

  // configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 22;
  localparam logic [CFG_ADDR_W-1:0] CFG_SNOW_THR   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SNOW_LIMIT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_MELT_BASE  = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_MELT_SLOPE = 2'd3;

  localparam logic [THR_W-1:0]   RST_SNOW_THR   = 13'd0;
  localparam logic [WATER_W-1:0] RST_SNOW_LIMIT = 22'd2560000;
  localparam logic [COEF_W-1:0]  RST_MELT_BASE  = 16'd384;
  localparam logic [COEF_W-1:0]  RST_MELT_SLOPE = 16'd459;

  // pool order
  localparam logic [POOL_IDX_W-1:0] POOL_NH4 = 2'd0;
  localparam logic [POOL_IDX_W-1:0] POOL_NO3 = 2'd1;
  localparam logic [POOL_IDX_W-1:0] POOL_P   = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

>>> rtl/snp_mult.sv
// snp_mult: shared 32x22 unsigned multiplier with registered product
// depends on snp_pkg
module snp_mult
  import snp_pkg::*;
(
  input  logic               clk,
  input  logic [MUL_A_W-1:0] mul_a,
  input  logic [MUL_B_W-1:0] mul_b,
  output logic [MUL_P_W-1:0] mul_p
);

  logic [MUL_P_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
  end

  assign mul_p = prod_r;

endmodule

>>> rtl/snp_divider.sv
// snp_divider: restoring divider, one quotient bit per cycle
// quotient must fit 32 bits (dividend < divisor * 2^32); depends on snp_pkg
module snp_divider
  import snp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DIV_N_W-1:0] dividend,
  input  logic [DIV_D_W-1:0] divisor,
  output logic [DIV_Q_W-1:0] quotient,
  output div_status_t        status
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_D_W-1:0]   rem_r;
  logic [DIV_D_W-1:0]   rem_nxt;
  logic [DIV_D_W-1:0]   dsr_r;
  logic [DIV_Q_W-1:0]   low_r;
  logic [DIV_Q_W-1:0]   q_r;
  logic [DIV_D_W:0]     trial;
  logic                 ge;
  logic                 last;

  assign trial   = {rem_r, low_r[DIV_Q_W-1]};
  assign ge      = trial >= {1'b0, dsr_r};
  assign rem_nxt = ge ? DIV_D_W'(trial - {1'b0, dsr_r}) : trial[DIV_D_W-1:0];
  assign last    = cnt_r == DIV_CNT_W'(DIV_Q_W - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[DIV_N_W-1:DIV_Q_W];
      low_r <= dividend[DIV_Q_W-1:0];
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      low_r <= {low_r[DIV_Q_W-2:0], 1'b0};
      q_r   <= {q_r[DIV_Q_W-2:0], ge};
    end
  end

  assign quotient    = q_r;
  assign status.busy = busy_r;
  assign status.done = done_r;

endmodule

>>> rtl/snowpack_nutrient_step_unit.sv
// snowpack_nutrient_step_unit: daily snowpack and nutrient pool step
// depends on snp_pkg, snp_mult, snp_divider
//
//   channel | direction | handshake            | word
//   --------+-----------+----------------------+-----------------------------------
//   in      | input     | in_valid / in_ready  | prec, air_temp, deposition, fert
//   out     | output    | out_valid / out_ready| water_to_soil, snow_water, to_soil, sat
//   cfg     | input     | cfg_we (no stall)    | cfg_addr, cfg_wdata
//
// one word at a time; in_ready is high only while the sequencer is idle
// a cold day goes from the branch step straight to pool handling; a warm day
//   first runs slope multiply, melt factor, low and high products, raw melt
// a melting day, or a cold day that sheds pack above a lowered limit, then runs
//   the pool steps; each pool costs a multiply, a divider start and a wait
//   on the bit-serial divider, which sets the rate
// a finished word waits in the output register; the next input word is taken
//   meanwhile, and the sequencer holds at its last step until that slot frees
// reset is synchronous: pools and snowpack clear, registers take defaults
module snowpack_nutrient_step_unit
  import snp_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  // input channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [PREC_W-1:0]         in_prec,
  input  logic signed [TEMP_W-1:0]  in_air_temp,
  input  logic [DEP_W-1:0]          in_nh4_dep,
  input  logic [DEP_W-1:0]          in_no3_dep,
  input  logic [DEP_W-1:0]          in_n_fert,
  input  logic [DEP_W-1:0]          in_p_dep,
  input  logic [DEP_W-1:0]          in_p_fert,
  // result channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [WATER_W-1:0]        out_water_to_soil,
  output logic [WATER_W-1:0]        out_snow_water,
  output logic [POOL_W-1:0]         out_nh4_to_soil,
  output logic [POOL_W-1:0]         out_no3_to_soil,
  output logic [POOL_W-1:0]         out_p_to_soil,
  output logic                      out_saturated,
  // configuration
  input  logic                      cfg_we,
  input  logic [CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [CFG_DATA_W-1:0]     cfg_wdata
);

  // sequencer codes
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_BRANCH = 4'd1;   // snowfall or melt decision
  localparam logic [3:0] ST_MF     = 4'd2;   // slope * prec
  localparam logic [3:0] ST_FAC    = 4'd3;   // melt factor
  localparam logic [3:0] ST_ML     = 4'd4;   // factor low word * dt
  localparam logic [3:0] ST_MH     = 4'd5;   // factor high bits * dt
  localparam logic [3:0] ST_RAW    = 4'd6;   // raw melt, capped by snowpack
  localparam logic [3:0] ST_POOL   = 4'd7;   // pick pool handling
  localparam logic [3:0] ST_PMUL   = 4'd8;   // pool * melt
  localparam logic [3:0] ST_PDIV   = 4'd9;   // start divide by snowpack before
  localparam logic [3:0] ST_PWAIT  = 4'd10;  // wait for quotient, update pool
  localparam logic [3:0] ST_DONE   = 4'd11;  // hand off to output register

  localparam int FAC_W = 36;

  // configuration registers
  logic [THR_W-1:0]   thr_r;
  logic [WATER_W-1:0] limit_r;
  logic [COEF_W-1:0]  base_r;
  logic [COEF_W-1:0]  slope_r;

  // architectural state
  logic [WATER_W-1:0] snow_store_r;
  logic [POOL_W-1:0]  pool_r [NUM_POOLS];

  // sequencer
  logic [3:0]            state_r;
  logic [3:0]            state_nxt;
  logic [POOL_IDX_W-1:0] k_r;

  // word being processed
  logic [PREC_W-1:0]   prec_r;
  logic [TEMP_W-1:0]   temp_r;
  logic [DEP_IN_W-1:0] dep_r [NUM_POOLS];
  logic [FAC_W-1:0]    factor_r;
  logic [47:0]         acc_r;
  logic [WATER_W-1:0]  melt_r;
  logic [WATER_W-1:0]  store_new_r;
  logic [WATER_W:0]    rain_r;
  logic [POOL_W-1:0]   nut_r [NUM_POOLS];
  logic                sat_r;

  // output register
  logic                out_valid_r;
  logic [WATER_W-1:0]  out_rain_r;
  logic [WATER_W-1:0]  out_snow_r;
  logic [POOL_W-1:0]   out_nut_r [NUM_POOLS];
  logic                out_sat_r;

  // shared units
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;
  logic [DIV_Q_W-1:0] div_q;
  div_status_t        div_st;

  // combinational helpers
  logic               accept;
  logic               out_free;
  logic [TEMP_W:0]    dt_full;
  logic [TEMP_W-1:0]  dt;
  logic               cold;
  logic [WATER_W-1:0] prec22;
  logic               store_ge;
  logic [WATER_W-1:0] excess;
  logic [WATER_W-1:0] room;
  logic [WATER_W-1:0] snow_add;
  logic [51:0]        melt_sum;
  logic [27:0]        raw_melt;
  logic [WATER_W-1:0] warm_melt;
  logic [WATER_W:0]   pack_total;
  logic               no_snow;
  logic               no_melt;
  logic [POOL_W:0]    pool_sum [NUM_POOLS];
  logic [POOL_W:0]    rel_sum;
  logic               pool_ovf;
  logic [DEP_IN_W-1:0] nh4_in;
  logic [DEP_IN_W-1:0] no3_in;
  logic [DEP_IN_W-1:0] p_in;

  assign accept   = in_valid && in_ready;
  assign in_ready = state_r == ST_IDLE;
  assign out_free = !out_valid_r || out_ready;

  // fertilizer nitrogen: ammonium takes the upper half
  assign nh4_in = DEP_IN_W'(in_nh4_dep) + DEP_IN_W'((DEP_IN_W'(in_n_fert) + 1'b1) >> 1);
  assign no3_in = DEP_IN_W'(in_no3_dep) + DEP_IN_W'(in_n_fert >> 1);
  assign p_in   = DEP_IN_W'(in_p_dep) + DEP_IN_W'(in_p_fert);

  // temperature above threshold; negative means snowfall
  assign dt_full = {temp_r[TEMP_W-1], temp_r} - {{(TEMP_W + 1 - THR_W){thr_r[THR_W-1]}}, thr_r};
  assign dt      = dt_full[TEMP_W-1:0];
  assign cold    = dt_full[TEMP_W];

  // snowfall path
  assign prec22   = WATER_W'(prec_r);
  assign store_ge = snow_store_r >= limit_r;
  assign excess   = snow_store_r - limit_r;
  assign room     = limit_r - snow_store_r;
  assign snow_add = (prec22 < room) ? prec22 : room;

  // melt path: (factor * dt) >> 24 from two partial products
  assign melt_sum  = {4'b0, acc_r} + {mul_p[19:0], 32'b0};
  assign raw_melt  = melt_sum[51:24];
  assign warm_melt = (raw_melt < 28'(snow_store_r)) ? raw_melt[WATER_W-1:0] : snow_store_r;

  assign pack_total = {1'b0, store_new_r} + {1'b0, melt_r};
  assign no_snow    = pack_total == '0;
  assign no_melt    = melt_r == '0;

  // deposition into pools when snow lies without melt
  always_comb begin
    pool_ovf = 1'b0;
    for (int i = 0; i < NUM_POOLS; i++) begin
      pool_sum[i] = {1'b0, pool_r[i]} + (POOL_W + 1)'(dep_r[i]);
      pool_ovf    = pool_ovf | pool_sum[i][POOL_W];
    end
  end

  // released mass plus deposition for the current pool
  assign rel_sum = {1'b0, div_q} + (POOL_W + 1)'(dep_r[k_r]);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_MF: begin
        mul_a = MUL_A_W'(slope_r);
        mul_b = MUL_B_W'(prec_r);
      end
      ST_ML: begin
        mul_a = factor_r[MUL_A_W-1:0];
        mul_b = MUL_B_W'(dt);
      end
      ST_MH: begin
        mul_a = MUL_A_W'(factor_r[FAC_W-1:MUL_A_W]);
        mul_b = MUL_B_W'(dt);
      end
      ST_PMUL: begin
        mul_a = pool_r[k_r];
        mul_b = melt_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  snp_mult u_mult (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .mul_p (mul_p)
  );

  snp_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == ST_PDIV),
    .dividend (mul_p),
    .divisor  (pack_total[DIV_D_W-1:0]),
    .quotient (div_q),
    .status   (div_st)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (accept) state_nxt = ST_BRANCH;
      ST_BRANCH: state_nxt = cold ? ST_POOL : ST_MF;
      ST_MF:     state_nxt = ST_FAC;
      ST_FAC:    state_nxt = ST_ML;
      ST_ML:     state_nxt = ST_MH;
      ST_MH:     state_nxt = ST_RAW;
      ST_RAW:    state_nxt = ST_POOL;
      ST_POOL:   state_nxt = (no_snow || no_melt) ? ST_DONE : ST_PMUL;
      ST_PMUL:   state_nxt = ST_PDIV;
      ST_PDIV:   state_nxt = ST_PWAIT;
      ST_PWAIT: begin
        if (!div_st.busy && div_st.done) begin
          state_nxt = (k_r == POOL_P) ? ST_DONE : ST_PMUL;
        end
      end
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // control state, configuration, snowpack and pools
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      thr_r        <= RST_SNOW_THR;
      limit_r      <= RST_SNOW_LIMIT;
      base_r       <= RST_MELT_BASE;
      slope_r      <= RST_MELT_SLOPE;
      snow_store_r <= '0;
      for (int i = 0; i < NUM_POOLS; i++) begin
        pool_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          CFG_SNOW_THR:   thr_r   <= cfg_wdata[THR_W-1:0];
          CFG_SNOW_LIMIT: limit_r <= cfg_wdata[WATER_W-1:0];
          CFG_MELT_BASE:  base_r  <= cfg_wdata[COEF_W-1:0];
          CFG_MELT_SLOPE: slope_r <= cfg_wdata[COEF_W-1:0];
          default: ;
        endcase
      end
      // the handoff below refills the slot in the same cycle it drains
      if (out_valid_r && out_ready && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_POOL: begin
          // snow without melt: deposition is stored, clipped at full scale
          if (!no_snow && no_melt) begin
            for (int i = 0; i < NUM_POOLS; i++) begin
              pool_r[i] <= pool_sum[i][POOL_W] ? '1 : pool_sum[i][POOL_W-1:0];
            end
          end
        end
        ST_PWAIT: begin
          if (!div_st.busy && div_st.done) begin
            pool_r[k_r] <= pool_r[k_r] - div_q;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            snow_store_r <= store_new_r;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      prec_r         <= in_prec;
      temp_r         <= in_air_temp;
      dep_r[POOL_NH4] <= nh4_in;
      dep_r[POOL_NO3] <= no3_in;
      dep_r[POOL_P]   <= p_in;
      sat_r          <= 1'b0;
    end
    case (state_r)
      ST_BRANCH: begin
        if (cold) begin
          if (store_ge) begin
            // lowered limit: excess leaves the snowpack as melt
            melt_r      <= excess;
            store_new_r <= limit_r;
            rain_r      <= {1'b0, prec22} + {1'b0, excess};
          end else begin
            melt_r      <= '0;
            store_new_r <= snow_store_r + snow_add;
            rain_r      <= {1'b0, prec22 - snow_add};
          end
        end
      end
      ST_FAC: begin
        factor_r <= {4'b0, base_r, 16'b0} + FAC_W'(mul_p[34:0]);
      end
      ST_MH: begin
        acc_r <= mul_p[47:0];
      end
      ST_RAW: begin
        melt_r      <= warm_melt;
        store_new_r <= snow_store_r - warm_melt;
        rain_r      <= {1'b0, prec22} + {1'b0, warm_melt};
      end
      ST_POOL: begin
        k_r <= POOL_NH4;
        if (no_snow) begin
          // no snow at all: deposition passes through
          for (int i = 0; i < NUM_POOLS; i++) begin
            nut_r[i] <= POOL_W'(dep_r[i]);
          end
        end else if (no_melt) begin
          for (int i = 0; i < NUM_POOLS; i++) begin
            nut_r[i] <= '0;
          end
          sat_r <= sat_r | pool_ovf;
        end
      end
      ST_PWAIT: begin
        if (!div_st.busy && div_st.done) begin
          nut_r[k_r] <= rel_sum[POOL_W] ? '1 : rel_sum[POOL_W-1:0];
          sat_r      <= sat_r | rel_sum[POOL_W];
          k_r        <= k_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_rain_r <= rain_r[WATER_W] ? '1 : rain_r[WATER_W-1:0];
          out_snow_r <= store_new_r;
          for (int i = 0; i < NUM_POOLS; i++) begin
            out_nut_r[i] <= nut_r[i];
          end
          out_sat_r  <= sat_r | rain_r[WATER_W];
        end
      end
      default: ;
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_water_to_soil = out_rain_r;
  assign out_snow_water    = out_snow_r;
  assign out_nh4_to_soil   = out_nut_r[POOL_NH4];
  assign out_no3_to_soil   = out_nut_r[POOL_NO3];
  assign out_p_to_soil     = out_nut_r[POOL_P];
  assign out_saturated     = out_sat_r;

endmodule

>>> test/snowpack_nutrient_step_unit_tb.sv
// testbench for snowpack_nutrient_step_unit: directed and random daily words, with
// configuration phases, checked against a bit-exact predictor in a scoreboard class
// depends on snp_pkg and the rtl of the unit
module snowpack_nutrient_step_unit_tb;
  import snp_pkg::*;

  localparam longint unsigned POOL_MAX  = (64'd1 << POOL_W) - 1;
  localparam longint unsigned WATER_MAX = (64'd1 << WATER_W) - 1;

  // one day of forcing
  typedef struct packed {
    logic [PREC_W-1:0] prec;
    logic [TEMP_W-1:0] air_temp;
    logic [DEP_W-1:0]  nh4_dep;
    logic [DEP_W-1:0]  no3_dep;
    logic [DEP_W-1:0]  n_fert;
    logic [DEP_W-1:0]  p_dep;
    logic [DEP_W-1:0]  p_fert;
  } day_in_t;

  // one day of soil input and snowpack state
  typedef struct packed {
    logic [WATER_W-1:0] water_to_soil;
    logic [WATER_W-1:0] snow_water;
    logic [POOL_W-1:0]  nh4_to_soil;
    logic [POOL_W-1:0]  no3_to_soil;
    logic [POOL_W-1:0]  p_to_soil;
    logic               saturated;
  } day_out_t;

  typedef enum {WX_MIXED, WX_HEAVY_DEP} weather_t;

  // mirror of the snowpack and pools, plus the queue of days still owed by the dut
  class snowpack_board;
    longint          thr;
    longint unsigned limit, base, slope;
    longint unsigned snow, nh4_pool, no3_pool, p_pool;
    day_out_t        due_q[$];
    int              errors;

    function void reset();
      thr      = longint'($signed(RST_SNOW_THR));
      limit    = 64'(RST_SNOW_LIMIT);
      base     = 64'(RST_MELT_BASE);
      slope    = 64'(RST_MELT_SLOPE);
      snow     = 0;
      nh4_pool = 0;
      no3_pool = 0;
      p_pool   = 0;
    endfunction

    function void set_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
      case (addr)
        CFG_SNOW_THR:   thr   = longint'($signed(data[THR_W-1:0]));
        CFG_SNOW_LIMIT: limit = 64'(data[WATER_W-1:0]);
        CFG_MELT_BASE:  base  = 64'(data[COEF_W-1:0]);
        CFG_MELT_SLOPE: slope = 64'(data[COEF_W-1:0]);
        default: ;
      endcase
    endfunction

    function longint unsigned clip32(longint unsigned v, inout bit flag);
      if (v > POOL_MAX) begin
        flag = 1'b1;
        return POOL_MAX;
      end
      return v;
    endfunction

    // one snowpack step: partition precipitation, melt, then move nutrients
    function day_out_t advance(day_in_t d);
      longint unsigned prec, nf, nh4_in, no3_in, p_in, store, melt, rain, pack_total;
      longint unsigned room, add, dt, factor, raw, a, b, c, o_nh4, o_no3, o_p;
      longint          temp;
      bit              sat;
      day_out_t        r;
      prec   = 64'(d.prec);
      temp   = longint'($signed(d.air_temp));
      nf     = 64'(d.n_fert);
      nh4_in = 64'(d.nh4_dep) + ((nf + 1) >> 1);
      no3_in = 64'(d.no3_dep) + (nf >> 1);
      p_in   = 64'(d.p_dep) + 64'(d.p_fert);
      store  = snow;
      melt   = 0;
      sat    = 1'b0;
      if (temp < thr) begin
        if (store >= limit) begin
          // pack above a lowered limit sheds the excess
          melt  = store - limit;
          store = limit;
          rain  = prec + melt;
        end else begin
          room  = limit - store;
          add   = (prec < room) ? prec : room;
          store = store + add;
          rain  = prec - add;
        end
      end else begin
        dt     = temp - thr;
        factor = (base << 16) + slope * prec;
        raw    = (factor * dt) >> 24;
        melt   = (raw < store) ? raw : store;
        store  = store - melt;
        rain   = prec + melt;
      end
      pack_total = store + melt;
      if (pack_total != 0) begin
        if (melt != 0) begin
          a        = (nh4_pool * melt) / pack_total;
          b        = (no3_pool * melt) / pack_total;
          c        = (p_pool * melt) / pack_total;
          o_nh4    = clip32(a + nh4_in, sat);
          o_no3    = clip32(b + no3_in, sat);
          o_p      = clip32(c + p_in, sat);
          nh4_pool = nh4_pool - a;
          no3_pool = no3_pool - b;
          p_pool   = p_pool - c;
        end else begin
          nh4_pool = clip32(nh4_pool + nh4_in, sat);
          no3_pool = clip32(no3_pool + no3_in, sat);
          p_pool   = clip32(p_pool + p_in, sat);
          o_nh4    = 0;
          o_no3    = 0;
          o_p      = 0;
        end
      end else begin
        o_nh4 = nh4_in;
        o_no3 = no3_in;
        o_p   = p_in;
      end
      if (rain > WATER_MAX) begin
        rain = WATER_MAX;
        sat  = 1'b1;
      end
      snow            = store & WATER_MAX;
      r.water_to_soil = rain[WATER_W-1:0];
      r.snow_water    = snow[WATER_W-1:0];
      r.nh4_to_soil   = o_nh4[POOL_W-1:0];
      r.no3_to_soil   = o_no3[POOL_W-1:0];
      r.p_to_soil     = o_p[POOL_W-1:0];
      r.saturated     = sat;
      return r;
    endfunction

    function void note_day(day_in_t d);
      due_q.push_back(advance(d));
    endfunction

    function void cmp(string field, longint unsigned want, longint unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_day(day_out_t got);
      day_out_t want;
      if (due_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, actual water_to_soil %0d snow_water %0d",
                 $time, got.water_to_soil, got.snow_water);
        return;
      end
      want = due_q.pop_front();
      cmp("water_to_soil", 64'(want.water_to_soil), 64'(got.water_to_soil));
      cmp("snow_water", 64'(want.snow_water), 64'(got.snow_water));
      cmp("nh4_to_soil", 64'(want.nh4_to_soil), 64'(got.nh4_to_soil));
      cmp("no3_to_soil", 64'(want.no3_to_soil), 64'(got.no3_to_soil));
      cmp("p_to_soil", 64'(want.p_to_soil), 64'(got.p_to_soil));
      cmp("saturated", 64'(want.saturated), 64'(got.saturated));
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic [PREC_W-1:0]       in_prec;
  logic signed [TEMP_W-1:0] in_air_temp;
  logic [DEP_W-1:0]        in_nh4_dep;
  logic [DEP_W-1:0]        in_no3_dep;
  logic [DEP_W-1:0]        in_n_fert;
  logic [DEP_W-1:0]        in_p_dep;
  logic [DEP_W-1:0]        in_p_fert;
  logic                    out_valid;
  logic                    out_ready;
  logic [WATER_W-1:0]      out_water_to_soil;
  logic [WATER_W-1:0]      out_snow_water;
  logic [POOL_W-1:0]       out_nh4_to_soil;
  logic [POOL_W-1:0]       out_no3_to_soil;
  logic [POOL_W-1:0]       out_p_to_soil;
  logic                    out_saturated;
  logic                    cfg_we;
  logic [CFG_ADDR_W-1:0]   cfg_addr;
  logic [CFG_DATA_W-1:0]   cfg_wdata;

  snowpack_board board;
  day_out_t      seen;
  bit            quiet;        // set near the end: no idling on either side
  bit            winter;       // current season of the random weather
  int            season_left;  // days left in that season

  snowpack_nutrient_step_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_prec           (in_prec),
    .in_air_temp       (in_air_temp),
    .in_nh4_dep        (in_nh4_dep),
    .in_no3_dep        (in_no3_dep),
    .in_n_fert         (in_n_fert),
    .in_p_dep          (in_p_dep),
    .in_p_fert         (in_p_fert),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_water_to_soil (out_water_to_soil),
    .out_snow_water    (out_snow_water),
    .out_nh4_to_soil   (out_nh4_to_soil),
    .out_no3_to_soil   (out_no3_to_soil),
    .out_p_to_soil     (out_p_to_soil),
    .out_saturated     (out_saturated),
    .cfg_we            (cfg_we),
    .cfg_addr          (cfg_addr),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case a handshake never completes
  initial begin
    #12000000;
    $display("status: fail");
    $finish;
  end

  // receiver: random stall bursts, none once quiet is set
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 13) - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // every result word accepted at a rising edge goes to the scoreboard
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen.water_to_soil = out_water_to_soil;
      seen.snow_water    = out_snow_water;
      seen.nh4_to_soil   = out_nh4_to_soil;
      seen.no3_to_soil   = out_no3_to_soil;
      seen.p_to_soil     = out_p_to_soil;
      seen.saturated     = out_saturated;
      board.check_day(seen);
    end
  end

  function automatic day_in_t mk_day(int prec, int temp, int nh4, int no3, int nf,
                                     int pd, int pf);
    day_in_t d;
    d.prec     = PREC_W'(prec);
    d.air_temp = TEMP_W'(temp);
    d.nh4_dep  = DEP_W'(nh4);
    d.no3_dep  = DEP_W'(no3);
    d.n_fert   = DEP_W'(nf);
    d.p_dep    = DEP_W'(pd);
    d.p_fert   = DEP_W'(pf);
    return d;
  endfunction

  // deposition: zero, full scale, any bit pattern, or a modest amount
  function automatic logic [DEP_W-1:0] pick_dep(bit heavy);
    int r;
    r = $urandom_range(0, 9);
    if (heavy && r < 7) return '1;
    case (r)
      0:       return '0;
      1:       return '1;
      2, 3, 4: return DEP_W'($urandom);
      default: return DEP_W'($urandom_range(0, 262144));
    endcase
  endfunction

  function automatic logic [PREC_W-1:0] pick_prec();
    int r;
    r = $urandom_range(0, 15);
    case (r)
      0, 1:       return '0;
      2:          return '1;
      3, 4, 5, 6: return PREC_W'($urandom);
      default:    return PREC_W'($urandom_range(0, 12800));
    endcase
  endfunction

  // seasons of cold days that build the pack, then warm days that melt it;
  // in mixed weather, one day in ten is pure noise over the whole field range
  function automatic day_in_t next_day(weather_t wx);
    day_in_t d;
    bit      heavy;
    heavy = (wx == WX_HEAVY_DEP);
    if (!heavy && $urandom_range(0, 9) == 0) begin
      d.prec     = PREC_W'($urandom);
      d.air_temp = TEMP_W'($urandom);
      d.nh4_dep  = DEP_W'($urandom);
      d.no3_dep  = DEP_W'($urandom);
      d.n_fert   = DEP_W'($urandom);
      d.p_dep    = DEP_W'($urandom);
      d.p_fert   = DEP_W'($urandom);
      return d;
    end
    if (season_left == 0) begin
      winter      = !winter;
      season_left = winter ? $urandom_range(2, heavy ? 160 : 25)
                           : $urandom_range(2, heavy ? 4 : 20);
    end
    season_left--;
    if ($urandom_range(0, 15) == 0)
      d.air_temp = 16'(board.thr - (winter ? 1 : 0));   // right at the threshold
    else if (winter)
      d.air_temp = 16'(board.thr - int'($urandom_range(1, 6000)));
    else
      d.air_temp = 16'(board.thr + int'($urandom_range(0, 6000)));
    d.prec    = pick_prec();
    d.nh4_dep = pick_dep(heavy);
    d.no3_dep = pick_dep(heavy);
    d.n_fert  = pick_dep(heavy);
    d.p_dep   = pick_dep(heavy);
    d.p_fert  = pick_dep(heavy);
    return d;
  endfunction

  // present one word and hold it until the unit takes it
  task automatic send_day(day_in_t d);
    @(negedge clk);
    in_valid    = 1'b1;
    in_prec     = d.prec;
    in_air_temp = d.air_temp;
    in_nh4_dep  = d.nh4_dep;
    in_no3_dep  = d.no3_dep;
    in_n_fert   = d.n_fert;
    in_p_dep    = d.p_dep;
    in_p_fert   = d.p_fert;
    do @(posedge clk); while (!in_ready);
    board.note_day(d);
  endtask

  task automatic hold_input(int n);
    @(negedge clk);
    in_valid = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // stop sending until every owed word has come back and the unit is idle
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (board.due_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = addr;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    board.set_reg(addr, data);
  endtask

  task automatic set_all(int thr, int lim, int mb, int ms);
    drain();
    write_reg(CFG_SNOW_THR, CFG_DATA_W'(thr));
    write_reg(CFG_SNOW_LIMIT, CFG_DATA_W'(lim));
    write_reg(CFG_MELT_BASE, CFG_DATA_W'(mb));
    write_reg(CFG_MELT_SLOPE, CFG_DATA_W'(ms));
  endtask

  // random days with sender gaps; idling stops for the last calm_tail days
  task automatic run_days(int n, weather_t wx, int calm_tail);
    for (int i = 0; i < n; i++) begin
      if (i == n - calm_tail) quiet = 1'b1;
      if (!quiet && $urandom_range(0, 9) == 0) hold_input($urandom_range(1, 13));
      if (!quiet && $urandom_range(0, 299) == 0) drain();
      send_day(next_day(wx));
    end
  endtask

  initial begin
    board       = new();
    board.reset();
    quiet       = 1'b0;
    winter      = 1'b0;
    season_left = 0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_prec     = '0;
    in_air_temp = '0;
    in_nh4_dep  = '0;
    in_no3_dep  = '0;
    in_n_fert   = '0;
    in_p_dep    = '0;
    in_p_fert   = '0;
    cfg_we      = 1'b0;
    cfg_addr    = CFG_SNOW_THR;
    cfg_wdata   = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed days at reset settings
    send_day(mk_day(0, 2560, 0, 0, 0, 0, 0));                          // bare ground
    send_day(mk_day(1000, 2560, 'hFFFFFF, 'hFFFFFF, 'hFFFFFF,          // pass-through,
                    'hFFFFFF, 'hFFFFFF));                               // odd fertilizer
    send_day(mk_day(2560, -512, 65536, 131072, 3, 65536, 65536));       // fresh snow only
    send_day(mk_day(0, -1, 'hFFFFFF, 'hFFFFFF, 'hFFFFFE,
                    'hFFFFFF, 'hFFFFFF));                               // cold, no prec
    send_day(mk_day(512, 0, 1000, 2000, 3000, 4000, 5000));             // at threshold
    send_day(mk_day(256, 1280, 100, 100, 100, 100, 100));               // partial melt
    send_day(mk_day(524287, 32767, 0, 0, 0, 0, 0));                     // melt capped
    send_day(mk_day(524287, -32768, 7, 7, 7, 7, 7));                    // coldest day
    send_day(mk_day(0, 256, 1, 2, 3, 4, 5));

    // fill the pack to the widest limit, then lower the limit under it
    drain();
    write_reg(CFG_SNOW_LIMIT, 22'h3FFFFF);
    repeat (9) send_day(mk_day(524287, -32768, 'hFFFFFF, 'hFFFFFF, 'hFFFFFF,
                                'hFFFFFF, 'hFFFFFF));
    drain();
    write_reg(CFG_SNOW_LIMIT, CFG_DATA_W'(1000));
    send_day(mk_day(524287, -256, 0, 0, 0, 0, 0));                     // excess shed, rain clips

    // threshold at both ends of its raw range, steepest melt factors
    drain();
    write_reg(CFG_MELT_BASE, 22'h00FFFF);
    write_reg(CFG_MELT_SLOPE, 22'h00FFFF);
    write_reg(CFG_SNOW_THR, 22'h000FFF);
    send_day(mk_day(524287, 32767, 9, 9, 9, 9, 9));
    drain();
    write_reg(CFG_SNOW_THR, 22'h3FF000);                               // upper bits ignored
    send_day(mk_day(0, -32768, 10, 20, 30, 40, 50));
    send_day(mk_day(100, -4096, 10, 20, 30, 40, 50));

    // random phases over several settings
    set_all(int'($signed(RST_SNOW_THR)), int'(RST_SNOW_LIMIT), int'(RST_MELT_BASE),
            int'(RST_MELT_SLOPE));
    run_days(400, WX_MIXED, 0);
    set_all(-2560, 0, 0, 0);                                          // no pack, no melt
    run_days(200, WX_MIXED, 0);
    set_all(2560, 2560000, 65535, 65535);                             // violent melt
    run_days(300, WX_MIXED, 0);
    set_all(4095, 'h3FFFFF, 384, 0);                                  // long winters fill pools
    run_days(250, WX_HEAVY_DEP, 0);
    set_all($urandom, $urandom, $urandom, $urandom);
    run_days(400, WX_MIXED, 0);
    set_all(int'($urandom_range(0, 5120)) - 2560, $urandom_range(0, 2560000),
            $urandom_range(0, 1024), $urandom_range(0, 2000));
    run_days(400, WX_MIXED, 150);

    @(negedge clk);
    in_valid = 1'b0;
    while (board.due_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (board.errors == 0 && board.due_q.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

>>> files.f
rtl/snp_pkg.sv
rtl/snp_mult.sv
rtl/snp_divider.sv
rtl/snowpack_nutrient_step_unit.sv
test/snowpack_nutrient_step_unit_tb.sv
